[hw/rtl/trs_pkg.sv]
package trs_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int TABLE_LEN     = 24;
    // CORDIC datapath width: sine/cosine fit in FRAC_BITS+2 bits plus guard
    localparam int CW            = FRAC_BITS + 3;
    localparam int ZW            = 33;
    localparam int PIPE_DEPTH    = CORDIC_STAGES + 4;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } trs_in_t;

    typedef struct packed {
        logic signed [31:0] m_r0_c0;
        logic signed [31:0] m_r0_c1;
        logic signed [31:0] m_r0_c2;
        logic signed [31:0] m_r0_c3;
        logic signed [31:0] m_r1_c0;
        logic signed [31:0] m_r1_c1;
        logic signed [31:0] m_r1_c2;
        logic signed [31:0] m_r1_c3;
        logic signed [31:0] m_r2_c0;
        logic signed [31:0] m_r2_c1;
        logic signed [31:0] m_r2_c2;
        logic signed [31:0] m_r2_c3;
    } trs_out_t;

    // Values carried along the CORDIC pipe besides the angles
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } trs_side_t;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] sz;
        logic signed [CW-1:0] cz;
    } trs_trig_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t [TABLE_LEN];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return t[i];
    endfunction

    localparam logic [63:0] GAIN_RAW = 64'h9B74EDA8 + (64'd1 << (31 - FRAC_BITS));
    localparam logic [63:0] GAIN_SH  = GAIN_RAW >> (32 - FRAC_BITS);
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(GAIN_SH);

    // Round a product back to FRAC_BITS, round half up
    function automatic logic signed [CW-1:0] rnd(input logic signed [2*CW-1:0] p);
        logic signed [2*CW-1:0] q;
        q = (p + (2*CW)'(64'd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return q[CW-1:0];
    endfunction

endpackage

[hw/rtl/trs_cordic.sv]
module trs_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [15:0]                       angle_x,
    input  logic [15:0]                       angle_y,
    input  logic [15:0]                       angle_z,
    input  trs_pkg::trs_side_t                in_side,
    output logic                              out_valid,
    output trs_pkg::trs_trig_t                out_trig,
    output trs_pkg::trs_side_t                out_side
);
    localparam int N  = trs_pkg::CORDIC_STAGES;
    localparam int CW = trs_pkg::CW;
    localparam int ZW = trs_pkg::ZW;

    logic signed [CW-1:0] x_reg [3][N+1];
    logic signed [CW-1:0] y_reg [3][N+1];
    logic signed [ZW-1:0] z_reg [3][N+1];
    logic                 f_reg [3][N+1];
    logic                 v_reg [N+1];
    trs_pkg::trs_side_t   s_reg [N+1];
    logic [15:0]          ang [3];

    assign ang[0] = angle_x;
    assign ang[1] = angle_y;
    assign ang[2] = angle_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < N; i++)
                v_reg[i+1] <= v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[0] <= in_side;
        for (int i = 0; i < N; i++)
            s_reg[i+1] <= s_reg[i];
        for (int a = 0; a < 3; a++)
        begin
            logic [31:0] w;
            logic        fl;
            w  = {ang[a], 16'h0000};
            fl = w[31] ^ w[30];
            if (fl)
                w[31] = ~w[31];
            z_reg[a][0] <= ZW'($signed(w));
            f_reg[a][0] <= fl;
            x_reg[a][0] <= trs_pkg::CORDIC_GAIN;
            y_reg[a][0] <= '0;
            for (int i = 0; i < N; i++)
            begin
                logic signed [CW-1:0] dx, dy;
                logic signed [ZW-1:0] at;
                dx = y_reg[a][i] >>> i;
                dy = x_reg[a][i] >>> i;
                at = ZW'(trs_pkg::atan_turn(i));
                if (!z_reg[a][i][ZW-1])
                begin
                    x_reg[a][i+1] <= x_reg[a][i] - dx;
                    y_reg[a][i+1] <= y_reg[a][i] + dy;
                    z_reg[a][i+1] <= z_reg[a][i] - at;
                end
                else
                begin
                    x_reg[a][i+1] <= x_reg[a][i] + dx;
                    y_reg[a][i+1] <= y_reg[a][i] - dy;
                    z_reg[a][i+1] <= z_reg[a][i] + at;
                end
                f_reg[a][i+1] <= f_reg[a][i];
            end
        end
    end

    function automatic logic signed [CW-1:0] fix(input logic f, input logic signed [CW-1:0] v);
        return f ? -v : v;
    endfunction

    assign out_valid   = v_reg[N];
    assign out_side    = s_reg[N];
    assign out_trig.cx = fix(f_reg[0][N], x_reg[0][N]);
    assign out_trig.sx = fix(f_reg[0][N], y_reg[0][N]);
    assign out_trig.cy = fix(f_reg[1][N], x_reg[1][N]);
    assign out_trig.sy = fix(f_reg[1][N], y_reg[1][N]);
    assign out_trig.cz = fix(f_reg[2][N], x_reg[2][N]);
    assign out_trig.sz = fix(f_reg[2][N], y_reg[2][N]);
endmodule

[hw/rtl/trs_matrix.sv]
module trs_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  trs_pkg::trs_trig_t in_trig,
    input  trs_pkg::trs_side_t in_side,
    output logic               out_valid,
    output trs_pkg::trs_out_t  out_m
);
    localparam int CW = trs_pkg::CW;
    localparam int PW = 2 * CW;
    localparam int FB = trs_pkg::FRAC_BITS;

    // stage A: first products
    logic signed [CW-1:0] czsy_reg, szsy_reg, r00_reg, r10_reg, szcx_reg, szsx_reg;
    logic signed [CW-1:0] czcx_reg, czsx_reg, r21_reg, r22_reg, r20_reg;
    logic signed [CW-1:0] sxa_reg, cxa_reg;
    trs_pkg::trs_side_t   sa_reg;
    // stage B: rotation entries
    logic signed [CW+1:0] r_reg [9];
    trs_pkg::trs_side_t   sb_reg;
    // stage C: scaled products
    logic signed [CW+33:0] p_reg [9];
    trs_pkg::trs_side_t    sc_reg;
    logic [2:0]            v_reg;

    function automatic logic signed [CW-1:0] mr(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return trs_pkg::rnd(p);
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [CW+33:0] p);
        logic signed [CW+33:0] q;
        q = (p + $signed((CW+34)'(64'd1 << (FB - 1)))) >>> FB;
        if (q > (CW+34)'(64'sd2147483647))
            return 32'sh7FFFFFFF;
        else if (q < -(CW+34)'(64'sd2147483648))
            return 32'sh80000000;
        return q[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        czsy_reg <= mr(in_trig.cz, in_trig.sy);
        szsy_reg <= mr(in_trig.sz, in_trig.sy);
        r00_reg  <= mr(in_trig.cz, in_trig.cy);
        r10_reg  <= mr(in_trig.sz, in_trig.cy);
        szcx_reg <= mr(in_trig.sz, in_trig.cx);
        szsx_reg <= mr(in_trig.sz, in_trig.sx);
        czcx_reg <= mr(in_trig.cz, in_trig.cx);
        czsx_reg <= mr(in_trig.cz, in_trig.sx);
        r21_reg  <= mr(in_trig.cy, in_trig.sx);
        r22_reg  <= mr(in_trig.cy, in_trig.cx);
        r20_reg  <= -in_trig.sy;
        sxa_reg  <= in_trig.sx;
        cxa_reg  <= in_trig.cx;
        sa_reg   <= in_side;

        r_reg[0] <= (CW+2)'(r00_reg);
        r_reg[1] <= (CW+2)'(mr(czsy_reg, sxa_reg)) - (CW+2)'(szcx_reg);
        r_reg[2] <= (CW+2)'(mr(czsy_reg, cxa_reg)) + (CW+2)'(szsx_reg);
        r_reg[3] <= (CW+2)'(r10_reg);
        r_reg[4] <= (CW+2)'(mr(szsy_reg, sxa_reg)) + (CW+2)'(czcx_reg);
        r_reg[5] <= (CW+2)'(mr(szsy_reg, cxa_reg)) - (CW+2)'(czsx_reg);
        r_reg[6] <= (CW+2)'(r20_reg);
        r_reg[7] <= (CW+2)'(r21_reg);
        r_reg[8] <= (CW+2)'(r22_reg);
        sb_reg   <= sa_reg;

        for (int k = 0; k < 9; k++)
        begin
            logic signed [31:0] s;
            case (k % 3)
                0:       s = sb_reg.scale_x;
                1:       s = sb_reg.scale_y;
                default: s = sb_reg.scale_z;
            endcase
            p_reg[k] <= (CW+34)'(r_reg[k]) * (CW+34)'(s);
        end
        sc_reg <= sb_reg;
    end

    assign out_valid      = v_reg[2];
    assign out_m.m_r0_c0  = sat(p_reg[0]);
    assign out_m.m_r0_c1  = sat(p_reg[1]);
    assign out_m.m_r0_c2  = sat(p_reg[2]);
    assign out_m.m_r0_c3  = sc_reg.pos_x;
    assign out_m.m_r1_c0  = sat(p_reg[3]);
    assign out_m.m_r1_c1  = sat(p_reg[4]);
    assign out_m.m_r1_c2  = sat(p_reg[5]);
    assign out_m.m_r1_c3  = sc_reg.pos_y;
    assign out_m.m_r2_c0  = sat(p_reg[6]);
    assign out_m.m_r2_c1  = sat(p_reg[7]);
    assign out_m.m_r2_c2  = sat(p_reg[8]);
    assign out_m.m_r2_c3  = sc_reg.pos_z;
endmodule

[hw/rtl/trs_model_matrix_core.sv]
// Model matrix core: builds the top three rows of T*Rz*Ry*Rx*S.
// Input channel: drive req and pulse start; a beat is taken at each
// rising edge with start high and busy low. busy is always low, so a
// new beat may enter every clock cycle.
// Output channel: each result beat appears on result for exactly one
// cycle with done high. The receiver cannot stall the block.
// Throughput: one beat per cycle. The CORDIC pipe (one stage per
// iteration) comes first; three product stages follow it.
// Reset clears all valid bits; no result appears until a beat is fed.
module trs_model_matrix_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  trs_pkg::trs_in_t  req,
    output logic              done,
    output trs_pkg::trs_out_t result
);
    trs_pkg::trs_side_t side_in, side_c;
    trs_pkg::trs_trig_t trig;
    logic               cv;

    assign busy = 1'b0;
    assign side_in.pos_x   = req.pos_x;
    assign side_in.pos_y   = req.pos_y;
    assign side_in.pos_z   = req.pos_z;
    assign side_in.scale_x = req.scale_x;
    assign side_in.scale_y = req.scale_y;
    assign side_in.scale_z = req.scale_z;

    trs_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .angle_x(req.angle_x), .angle_y(req.angle_y), .angle_z(req.angle_z),
        .in_side(side_in), .out_valid(cv), .out_trig(trig), .out_side(side_c)
    );

    trs_matrix u_matrix (
        .clk(clk), .rst_n(rst_n), .in_valid(cv), .in_trig(trig),
        .in_side(side_c), .out_valid(done), .out_m(result)
    );

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        cv |-> ##3 done) else $error("result lost after cordic");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cv |-> ##3 (result.m_r0_c3 == $past(side_c.pos_x, 3)))
        else $error("translation mismatch");
    a_nodone: assert property (@(posedge clk) disable iff (!rst_n)
        !cv |-> ##3 !done) else $error("spurious result");
endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int N_STAGES = trs_pkg::CORDIC_STAGES;
    localparam int FB       = trs_pkg::FRAC_BITS;
    localparam int LATENCY  = trs_pkg::PIPE_DEPTH;
    localparam int WD_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    trs_pkg::trs_in_t  req;
    logic              done;
    trs_pkg::trs_out_t result;

    trs_pkg::trs_out_t matrix_q[$];
    int                fail_cnt;
    int                idle_pct;
    int                quiet_cycles;

    trs_model_matrix_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return floor_shr(a * b + (64'sd1 <<< (FB - 1)), FB);
    endfunction

    function automatic logic [31:0] atan_step(int i);
        logic [31:0] t [24];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return t[i];
    endfunction

    task automatic cordic_sincos(input logic [15:0] ang, output longint s,
                                 output longint c);
        logic [31:0] a;
        logic        flip;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        a = {ang, 16'h0000};
        flip = a[31] ^ a[30];
        if (flip)
            a[31] = ~a[31];
        z = longint'(signed'(a));
        x = longint'((64'h9B74EDA8 + (64'd1 << (31 - FB))) >> (32 - FB));
        y = 0;
        for (int i = 0; i < N_STAGES; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_step(i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_step(i));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic logic [31:0] scale_clip(longint r, logic signed [31:0] sc);
        longint v;
        v = floor_shr(r * longint'(sc) + (64'sd1 <<< (FB - 1)), FB);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic model_matrix(input trs_pkg::trs_in_t it, output trs_pkg::trs_out_t m);
        longint sx, cx, sy, cy, sz, cz;
        longint r [3][3];
        cordic_sincos(it.angle_x, sx, cx);
        cordic_sincos(it.angle_y, sy, cy);
        cordic_sincos(it.angle_z, sz, cz);
        r[0][0] = q_mul(cz, cy);
        r[0][1] = q_mul(q_mul(cz, sy), sx) - q_mul(sz, cx);
        r[0][2] = q_mul(q_mul(cz, sy), cx) + q_mul(sz, sx);
        r[1][0] = q_mul(sz, cy);
        r[1][1] = q_mul(q_mul(sz, sy), sx) + q_mul(cz, cx);
        r[1][2] = q_mul(q_mul(sz, sy), cx) - q_mul(cz, sx);
        r[2][0] = -sy;
        r[2][1] = q_mul(cy, sx);
        r[2][2] = q_mul(cy, cx);
        m.m_r0_c0 = scale_clip(r[0][0], it.scale_x);
        m.m_r0_c1 = scale_clip(r[0][1], it.scale_y);
        m.m_r0_c2 = scale_clip(r[0][2], it.scale_z);
        m.m_r0_c3 = it.pos_x;
        m.m_r1_c0 = scale_clip(r[1][0], it.scale_x);
        m.m_r1_c1 = scale_clip(r[1][1], it.scale_y);
        m.m_r1_c2 = scale_clip(r[1][2], it.scale_z);
        m.m_r1_c3 = it.pos_y;
        m.m_r2_c0 = scale_clip(r[2][0], it.scale_x);
        m.m_r2_c1 = scale_clip(r[2][1], it.scale_y);
        m.m_r2_c2 = scale_clip(r[2][2], it.scale_z);
        m.m_r2_c3 = it.pos_z;
    endtask

    // Send one beat; random idle cycles ahead of it
    task automatic send_beat(input trs_pkg::trs_in_t it);
        trs_pkg::trs_out_t m;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model_matrix(it, m);
        matrix_q.push_back(m);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h00010000 * $urandom_range(8);
            3: return -(32'h00010000 * $urandom_range(8));
            4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic trs_pkg::trs_in_t rand_item();
        trs_pkg::trs_in_t it;
        it.pos_x   = $urandom;
        it.pos_y   = $urandom;
        it.pos_z   = $urandom;
        it.angle_x = 16'($urandom);
        it.angle_y = 16'($urandom);
        it.angle_z = 16'($urandom);
        it.scale_x = rand_word();
        it.scale_y = rand_word();
        it.scale_z = rand_word();
        return it;
    endfunction

    task automatic test_directed();
        trs_pkg::trs_in_t it;
        logic [15:0] angs [10];
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                 16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h2000};
        idle_pct = 0;
        for (int i = 0; i < 10; i++)
        begin
            it.pos_x   = 32'h80000000;
            it.pos_y   = 32'h7FFFFFFF;
            it.pos_z   = 32'hFFFFFFFF;
            it.angle_x = angs[i];
            it.angle_y = angs[(i + 3) % 10];
            it.angle_z = angs[(i + 7) % 10];
            it.scale_x = 32'h00010000;
            it.scale_y = 32'h00010000;
            it.scale_z = 32'h00010000;
            send_beat(it);
        end
        // saturation at both extremes of the scale
        for (int i = 0; i < 6; i++)
        begin
            it = rand_item();
            it.scale_x = i[0] ? 32'h80000000 : 32'h7FFFFFFF;
            it.scale_y = i[1] ? 32'h80000000 : 32'h7FFFFFFF;
            it.scale_z = i[2] ? 32'h7FFFFFFF : 32'h80000000;
            it.angle_x = angs[i];
            send_beat(it);
        end
        it = '0;
        send_beat(it);
        it = '1;
        send_beat(it);
        stop_sending();
    endtask

    task automatic test_random(input int n, input int pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++)
            send_beat(rand_item());
        stop_sending();
    endtask

    // Check each result beat against the oldest expected matrix
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (matrix_q.size() == 0)
            begin
                $error("result beat with no matrix expected");
                fail_cnt++;
            end
            else
            begin
                trs_pkg::trs_out_t e;
                e = matrix_q.pop_front();
                if (result.m_r0_c0 !== e.m_r0_c0)
                begin
                    $error("m_r0_c0 exp %h got %h", e.m_r0_c0, result.m_r0_c0);
                    fail_cnt++;
                end
                if (result.m_r0_c1 !== e.m_r0_c1)
                begin
                    $error("m_r0_c1 exp %h got %h", e.m_r0_c1, result.m_r0_c1);
                    fail_cnt++;
                end
                if (result.m_r0_c2 !== e.m_r0_c2)
                begin
                    $error("m_r0_c2 exp %h got %h", e.m_r0_c2, result.m_r0_c2);
                    fail_cnt++;
                end
                if (result.m_r0_c3 !== e.m_r0_c3)
                begin
                    $error("m_r0_c3 exp %h got %h", e.m_r0_c3, result.m_r0_c3);
                    fail_cnt++;
                end
                if (result.m_r1_c0 !== e.m_r1_c0)
                begin
                    $error("m_r1_c0 exp %h got %h", e.m_r1_c0, result.m_r1_c0);
                    fail_cnt++;
                end
                if (result.m_r1_c1 !== e.m_r1_c1)
                begin
                    $error("m_r1_c1 exp %h got %h", e.m_r1_c1, result.m_r1_c1);
                    fail_cnt++;
                end
                if (result.m_r1_c2 !== e.m_r1_c2)
                begin
                    $error("m_r1_c2 exp %h got %h", e.m_r1_c2, result.m_r1_c2);
                    fail_cnt++;
                end
                if (result.m_r1_c3 !== e.m_r1_c3)
                begin
                    $error("m_r1_c3 exp %h got %h", e.m_r1_c3, result.m_r1_c3);
                    fail_cnt++;
                end
                if (result.m_r2_c0 !== e.m_r2_c0)
                begin
                    $error("m_r2_c0 exp %h got %h", e.m_r2_c0, result.m_r2_c0);
                    fail_cnt++;
                end
                if (result.m_r2_c1 !== e.m_r2_c1)
                begin
                    $error("m_r2_c1 exp %h got %h", e.m_r2_c1, result.m_r2_c1);
                    fail_cnt++;
                end
                if (result.m_r2_c2 !== e.m_r2_c2)
                begin
                    $error("m_r2_c2 exp %h got %h", e.m_r2_c2, result.m_r2_c2);
                    fail_cnt++;
                end
                if (result.m_r2_c3 !== e.m_r2_c3)
                begin
                    $error("m_r2_c3 exp %h got %h", e.m_r2_c3, result.m_r2_c3);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("trs_model_matrix_core test failed");
            $finish;
        end
    end

    initial
    begin
        fail_cnt = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 37);
        test_random(400, 62);
        test_random(400, 0);
        while (matrix_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (fail_cnt == 0)
            $display("trs_model_matrix_core test passed");
        else
            $display("trs_model_matrix_core test failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/trs_pkg.sv
hw/rtl/trs_cordic.sv
hw/rtl/trs_matrix.sv
hw/rtl/trs_model_matrix_core.sv
dv/testbench.sv
